@@ sv/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants of the sensor spike trigger unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned SEC_W      = 16;
    localparam int unsigned MS_W       = 26;
    localparam int unsigned REF_W      = 11;
    localparam int unsigned AVG_W      = 10;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned PCT_W      = 8;
    localparam int unsigned LIMIT_W    = 9;
    localparam int unsigned PROD_W     = 18;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [MS_W-1:0]          MS_PER_S         = MS_W'(1000);
    localparam logic [PROD_W-1:0]        PCT_SCALE        = PROD_W'(100);
    localparam logic [CNT_W-1:0]         CNT_MAX          = '1;
    localparam logic signed [LIMIT_W-1:0] REPEAT_UNLIMITED = '1;

    localparam logic [1:0] SEL_ONE    = 2'd1;
    localparam logic [1:0] SEL_TWO    = 2'd2;
    localparam logic       OP_EVAL    = 1'b0;
    localparam logic       OP_RESTART = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_SELECT  = 3'd0,
        REG_RISE_DIRECTION = 3'd1,
        REG_STOP_MODE      = 3'd2,
        REG_THRESHOLD_PCT  = 3'd3,
        REG_COOLDOWN_S     = 3'd4,
        REG_WINDOW_START_S = 3'd5,
        REG_WINDOW_END_S   = 3'd6,
        REG_REPEAT_LIMIT   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]                sensor_select;
        logic                      rise_direction;
        logic                      stop_mode;
        logic [PCT_W-1:0]          threshold_pct;
        logic [MS_W-1:0]           cooldown_ms;
        logic [MS_W-1:0]           window_start_ms;
        logic [MS_W-1:0]           window_end_ms;
        logic signed [LIMIT_W-1:0] repeat_limit;
    } t_cfg;

    typedef struct packed {
        logic                     op;
        logic [TIME_W-1:0]        now_ms;
        logic [TIME_W-1:0]        play_ms;
        logic signed [REF_W-1:0]  reference_one;
        logic signed [REF_W-1:0]  reference_two;
        logic [AVG_W-1:0]         average_one;
        logic [AVG_W-1:0]         average_two;
    } t_item;

    typedef struct packed {
        logic [TIME_W-1:0] last_fire_ms;
        logic              never_fired;
        logic [CNT_W-1:0]  fire_counter;
    } t_state;

    typedef struct packed {
        logic             fired;
        logic             stop_command;
        logic [AVG_W-1:0] new_reference;
        logic             exhausted;
        logic [CNT_W-1:0] fire_count;
    } t_result;

endpackage

`default_nettype wire

@@ sv/sst_if.sv @@
// ----------------------------------------------------------------------------
// sst_if
// Valid/ready channel interfaces: sample input, result output, register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_in_if import sst_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [TIME_W-1:0]       now_ms;
    logic [TIME_W-1:0]       play_ms;
    logic signed [REF_W-1:0] reference_one;
    logic signed [REF_W-1:0] reference_two;
    logic [AVG_W-1:0]        average_one;
    logic [AVG_W-1:0]        average_two;

    modport source (output valid, op, now_ms, play_ms, reference_one, reference_two,
                    average_one, average_two, input ready);
    modport sink   (input valid, op, now_ms, play_ms, reference_one, reference_two,
                    average_one, average_two, output ready);
endinterface

interface sst_out_if import sst_pkg::*;;
    logic             valid;
    logic             ready;
    logic             fired;
    logic             stop_command;
    logic [AVG_W-1:0] new_reference;
    logic             exhausted;
    logic [CNT_W-1:0] fire_count;

    modport source (output valid, fired, stop_command, new_reference, exhausted,
                    fire_count, input ready);
    modport sink   (input valid, fired, stop_command, new_reference, exhausted,
                    fire_count, output ready);
endinterface

interface sst_cfg_if import sst_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/sst_eval.sv @@
// ----------------------------------------------------------------------------
// sst_eval
// Spike decision for one sample: selects the sensor, checks cooldown, window,
// direction and percent change, and forms the result and the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_eval import sst_pkg::*; (
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  t_state  i_state,
    output t_result o_result,
    output t_state  o_state
);

    logic                    sel_one;
    logic                    sel_ok;
    logic signed [REF_W-1:0] ref_val;
    logic [AVG_W-1:0]        ref_mag;
    logic [AVG_W-1:0]        avg;
    logic                    ref_pos;
    logic                    rollback;
    logic [TIME_W-1:0]       last_eff;
    logic                    cool;
    logic                    win;
    logic                    dir_ok;
    logic [AVG_W-1:0]        diff;
    logic [PROD_W-1:0]       lhs;
    logic [PROD_W-1:0]       rhs;
    logic                    fire;
    logic [CNT_W-1:0]        cnt_next;

    always_comb begin
        sel_one = (i_cfg.sensor_select == SEL_ONE);
        sel_ok  = sel_one || (i_cfg.sensor_select == SEL_TWO);
        ref_val = sel_one ? i_item.reference_one : i_item.reference_two;
        avg     = sel_one ? i_item.average_one : i_item.average_two;
        ref_pos = !ref_val[REF_W-1] && (ref_val != '0);
        ref_mag = ref_val[AVG_W-1:0];

        // clock rollback pulls the stored time back to now
        rollback = !i_state.never_fired && (i_state.last_fire_ms > i_item.now_ms);
        last_eff = rollback ? i_item.now_ms : i_state.last_fire_ms;

        cool = i_state.never_fired ||
               ({1'b0, i_item.now_ms} >
                ({1'b0, last_eff} + (TIME_W+1)'(i_cfg.cooldown_ms)));

        win = (i_cfg.window_end_ms == '0) ||
              ((TIME_W'(i_cfg.window_start_ms) <= i_item.play_ms) &&
               (i_item.play_ms < TIME_W'(i_cfg.window_end_ms)));

        dir_ok = i_cfg.rise_direction ? (avg > ref_mag) : (avg < ref_mag);
        diff   = (avg > ref_mag) ? (avg - ref_mag) : (ref_mag - avg);
        lhs    = PROD_W'(diff) * PCT_SCALE;
        rhs    = PROD_W'(i_cfg.threshold_pct) * PROD_W'(ref_mag);

        fire = (i_item.op == OP_EVAL) && sel_ok && ref_pos && cool && win &&
               dir_ok && (lhs >= rhs);

        if (i_item.op == OP_RESTART) begin
            o_state.last_fire_ms = '0;
            o_state.never_fired  = 1'b1;
            o_state.fire_counter = '0;
        end else begin
            o_state.last_fire_ms = fire ? i_item.now_ms : last_eff;
            o_state.never_fired  = fire ? 1'b0 : i_state.never_fired;
            o_state.fire_counter = (fire && (i_state.fire_counter != CNT_MAX)) ?
                                   i_state.fire_counter + CNT_W'(1) :
                                   i_state.fire_counter;
        end
        cnt_next = o_state.fire_counter;

        o_result.fired         = fire;
        o_result.stop_command  = fire && i_cfg.stop_mode;
        o_result.new_reference = fire ? avg : '0;
        o_result.exhausted     = (i_cfg.repeat_limit != REPEAT_UNLIMITED) &&
                                 (i_cfg.repeat_limit[LIMIT_W-1] ||
                                  (cnt_next >= i_cfg.repeat_limit[CNT_W-1:0]));
        o_result.fire_count    = cnt_next;
    end

endmodule

`default_nettype wire

@@ sv/sensor_spike_trigger_unit.sv @@
// ----------------------------------------------------------------------------
// sensor_spike_trigger_unit
// Spike trigger on one of two sensor averages against their references.
//
// i_in carries one sample per word: op (evaluate or restart), current time,
// play time, and reference and average of both sensors. o_out returns one
// result word per sample: fired, command kind, new reference, exhausted flag
// and the fire count. i_cfg writes the eight control registers by index and
// is always ready; scaled millisecond limits are computed as a register is
// written.
// A sample is registered in the input register, then decided combinationally
// into the result register when o_out is not stalled. One sample per cycle is
// sustained while o_out accepts; the stored fire time and count load with each result, so the next sample sees them.
// When o_out stalls the result holds and one more sample waits in the input
// register; i_in.ready drops only while both are full.
// Reset clears both stages, the fire count and stored time, and loads the
// register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_spike_trigger_unit import sst_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sst_in_if.sink     i_in,
    sst_out_if.source  o_out,
    sst_cfg_if.sink    i_cfg
);

    t_cfg    r_cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    advance;
    logic    take_in;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign take_in     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_select   <= '0;
            r_cfg.rise_direction  <= 1'b0;
            r_cfg.stop_mode       <= 1'b0;
            r_cfg.threshold_pct   <= PCT_W'(10);
            r_cfg.cooldown_ms     <= MS_W'(5) * MS_PER_S;
            r_cfg.window_start_ms <= '0;
            r_cfg.window_end_ms   <= '0;
            r_cfg.repeat_limit    <= REPEAT_UNLIMITED;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_SENSOR_SELECT:  r_cfg.sensor_select   <= i_cfg.data[1:0];
                REG_RISE_DIRECTION: r_cfg.rise_direction  <= i_cfg.data[0];
                REG_STOP_MODE:      r_cfg.stop_mode       <= i_cfg.data[0];
                REG_THRESHOLD_PCT:  r_cfg.threshold_pct   <= i_cfg.data[PCT_W-1:0];
                REG_COOLDOWN_S:     r_cfg.cooldown_ms     <= MS_W'(i_cfg.data) * MS_PER_S;
                REG_WINDOW_START_S: r_cfg.window_start_ms <= MS_W'(i_cfg.data) * MS_PER_S;
                REG_WINDOW_END_S:   r_cfg.window_end_ms   <= MS_W'(i_cfg.data) * MS_PER_S;
                REG_REPEAT_LIMIT:   r_cfg.repeat_limit    <= i_cfg.data[LIMIT_W-1:0];
                default:            r_cfg                 <= r_cfg;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_item.op            <= i_in.op;
            r_item.now_ms        <= i_in.now_ms;
            r_item.play_ms       <= i_in.play_ms;
            r_item.reference_one <= i_in.reference_one;
            r_item.reference_two <= i_in.reference_two;
            r_item.average_one   <= i_in.average_one;
            r_item.average_two   <= i_in.average_two;
        end
    end

    sst_eval u_eval (
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_result (n_res),
        .o_state  (n_state)
    );

    // trigger state and result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_fire_ms <= '0;
            r_state.never_fired  <= 1'b1;
            r_state.fire_counter <= '0;
            r_out_valid          <= 1'b0;
        end else begin
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.fired         = r_res.fired;
    assign o_out.stop_command  = r_res.stop_command;
    assign o_out.new_reference = r_res.new_reference;
    assign o_out.exhausted     = r_res.exhausted;
    assign o_out.fire_count    = r_res.fire_count;

endmodule

`default_nettype wire

@@ sv/sst_checker.sv @@
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks of the sensor spike trigger unit, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_checker import sst_pkg::*; (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_out_valid,
    input wire             i_out_ready,
    input wire             i_fired,
    input wire             i_stop_command,
    input wire [AVG_W-1:0] i_new_reference,
    input wire [CNT_W-1:0] i_fire_count
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_fire_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_fired |-> i_fire_count != '0)
        else $error("fired with zero count");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_fired |-> !i_stop_command && (i_new_reference == '0))
        else $error("command fields set without firing");

endmodule

bind sensor_spike_trigger_unit sst_checker u_sst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_fired         (o_out.fired),
    .i_stop_command  (o_out.stop_command),
    .i_new_reference (o_out.new_reference),
    .i_fire_count    (o_out.fire_count)
);

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor spike trigger unit. Sample words go in
// through a bursty sender, result words come back through a stalling
// receiver. A cycle-free predictor with its own copy of the registers and the
// fire state computes every expected result word at the moment the sample is
// accepted; results are compared in order. Directed checks cover the
// cooldown, clock rollback, window and threshold edges, exhaustion and
// restart; random phases with random register settings and counter
// saturation follow.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sst_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sst_in_if  in_ch ();
    sst_out_if out_ch ();
    sst_cfg_if cfg_ch ();

    sensor_spike_trigger_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [1:0]                cur_sel    = '0;
    logic                      cur_rise   = 1'b0;
    logic                      cur_stop   = 1'b0;
    logic [PCT_W-1:0]          cur_pct    = PCT_W'(10);
    logic [SEC_W-1:0]          cur_cool   = SEC_W'(5);
    logic [SEC_W-1:0]          cur_wstart = '0;
    logic [SEC_W-1:0]          cur_wend   = '0;
    logic signed [LIMIT_W-1:0] cur_limit  = REPEAT_UNLIMITED;

    // predictor copy of the fire state
    logic [TIME_W-1:0] last_fire_ms = '0;
    logic              never_fired  = 1'b1;
    logic [CNT_W-1:0]  fire_count   = '0;

    t_result     pending_results[$];
    int          mismatch_cnt = 0;
    int          burst_left   = 0;
    int          gap_max      = 0;
    int          stall_mode   = 0;
    int unsigned stall_cyc    = 0;
    int unsigned run_ms       = 0;

    function automatic t_result predict_trigger(t_item it);
        t_result     res;
        int          sref;
        int          savg;
        int          diff;
        int          lim;
        logic [47:0] due_ms;
        logic [47:0] play_w;
        logic        cool_ok;
        logic        win_ok;
        logic        dir_ok;
        res = '0;
        if (it.op == OP_RESTART) begin
            fire_count   = '0;
            last_fire_ms = '0;
            never_fired  = 1'b1;
        end else begin
            if (!never_fired && last_fire_ms > it.now_ms)
                last_fire_ms = it.now_ms;
            if (cur_sel == SEL_ONE) begin
                sref = $signed(it.reference_one);
                savg = it.average_one;
            end else begin
                sref = $signed(it.reference_two);
                savg = it.average_two;
            end
            due_ms  = 48'(last_fire_ms) + 48'(cur_cool) * 48'd1000;
            cool_ok = never_fired || (48'(it.now_ms) > due_ms);
            play_w  = 48'(it.play_ms);
            win_ok  = (cur_wend == 0) ||
                      (48'(cur_wstart) * 48'd1000 <= play_w &&
                       play_w < 48'(cur_wend) * 48'd1000);
            dir_ok  = cur_rise ? (savg > sref) : (savg < sref);
            diff    = (sref > savg) ? sref - savg : savg - sref;
            if ((cur_sel == SEL_ONE || cur_sel == SEL_TWO) && sref > 0 && cool_ok &&
                win_ok && dir_ok && diff * 100 >= int'(cur_pct) * sref) begin
                res.fired         = 1'b1;
                res.stop_command  = cur_stop;
                res.new_reference = AVG_W'(savg);
                last_fire_ms      = it.now_ms;
                never_fired       = 1'b0;
                if (fire_count != CNT_MAX)
                    fire_count++;
            end
        end
        lim = cur_limit;
        res.exhausted  = (cur_limit != REPEAT_UNLIMITED) && (int'(fire_count) >= lim);
        res.fire_count = fire_count;
        return res;
    endfunction

    function automatic string show_result(t_result r);
        return $sformatf("fired=%0d stop=%0d new_ref=%0d exhausted=%0d count=%0d",
                         r.fired, r.stop_command, r.new_reference, r.exhausted,
                         r.fire_count);
    endfunction

    task automatic flag_error(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t ns: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        stall_cyc++;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.fired         = out_ch.fired;
            got.stop_command  = out_ch.stop_command;
            got.new_reference = out_ch.new_reference;
            got.exhausted     = out_ch.exhausted;
            got.fire_count    = out_ch.fire_count;
            if (pending_results.size() == 0) begin
                flag_error({"result word with nothing pending: ", show_result(got)});
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    flag_error({"expected ", show_result(want), " got ", show_result(got)});
            end
        end
        case (stall_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 9) >= 3);
            2:       out_ch.ready <= ((stall_cyc % 16) >= 5);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_SENSOR_SELECT:  cur_sel    = val[1:0];
            REG_RISE_DIRECTION: cur_rise   = val[0];
            REG_STOP_MODE:      cur_stop   = val[0];
            REG_THRESHOLD_PCT:  cur_pct    = val[PCT_W-1:0];
            REG_COOLDOWN_S:     cur_cool   = val[SEC_W-1:0];
            REG_WINDOW_START_S: cur_wstart = val[SEC_W-1:0];
            REG_WINDOW_END_S:   cur_wend   = val[SEC_W-1:0];
            REG_REPEAT_LIMIT:   cur_limit  = val[LIMIT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [1:0] sel, logic rise, logic stop,
                              logic [PCT_W-1:0] pct, logic [SEC_W-1:0] cool,
                              logic [SEC_W-1:0] wstart, logic [SEC_W-1:0] wend,
                              logic [LIMIT_W-1:0] lim);
        write_reg(REG_SENSOR_SELECT, CFG_DATA_W'(sel));
        write_reg(REG_RISE_DIRECTION, CFG_DATA_W'(rise));
        write_reg(REG_STOP_MODE, CFG_DATA_W'(stop));
        write_reg(REG_THRESHOLD_PCT, CFG_DATA_W'(pct));
        write_reg(REG_COOLDOWN_S, cool);
        write_reg(REG_WINDOW_START_S, wstart);
        write_reg(REG_WINDOW_END_S, wend);
        write_reg(REG_REPEAT_LIMIT, CFG_DATA_W'(lim));
    endtask

    task automatic send_sample(t_item it);
        in_ch.valid         <= 1'b1;
        in_ch.op            <= it.op;
        in_ch.now_ms        <= it.now_ms;
        in_ch.play_ms       <= it.play_ms;
        in_ch.reference_one <= it.reference_one;
        in_ch.reference_two <= it.reference_two;
        in_ch.average_one   <= it.average_one;
        in_ch.average_two   <= it.average_two;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(predict_trigger(it));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (gap_max > 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
        end
    endtask

    // hold off the sender until every pending result word is back
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_item sample(logic op, logic [TIME_W-1:0] now_ms,
                                     logic [TIME_W-1:0] play_ms,
                                     logic signed [REF_W-1:0] ref_one,
                                     logic [AVG_W-1:0] avg_one,
                                     logic signed [REF_W-1:0] ref_two,
                                     logic [AVG_W-1:0] avg_two);
        t_item it;
        it.op            = op;
        it.now_ms        = now_ms;
        it.play_ms       = play_ms;
        it.reference_one = ref_one;
        it.average_one   = avg_one;
        it.reference_two = ref_two;
        it.average_two   = avg_two;
        return it;
    endfunction

    function automatic logic signed [REF_W-1:0] pick_reference();
        case ($urandom_range(0, 19))
            0:       return -11'sd1;
            1:       return 11'sd0;
            2, 3:    return REF_W'($urandom_range(0, 2047));
            default: return REF_W'($urandom_range(1, 1023));
        endcase
    endfunction

    // mostly near the configured direction, some right at the threshold
    function automatic logic [AVG_W-1:0] pick_average(int r);
        int   d;
        int   a;
        logic up;
        if (r <= 0 || $urandom_range(0, 9) == 0)
            return AVG_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 3) == 0)
            d = (int'(cur_pct) * r + 99) / 100 + int'($urandom_range(0, 2)) - 1;
        else
            d = int'($urandom_range(0, r));
        up = ($urandom_range(0, 3) == 0) ? !cur_rise : cur_rise;
        a  = up ? r + d : r - d;
        if (a < 0)
            a = 0;
        if (a > 1023)
            a = 1023;
        return AVG_W'(a);
    endfunction

    function automatic t_item random_sample();
        t_item       it;
        int unsigned span;
        int unsigned lo;
        int unsigned hi;
        it.op = ($urandom_range(0, 39) == 0) ? OP_RESTART : OP_EVAL;
        span  = cur_cool * 1000;
        case ($urandom_range(0, 24))
            0:       run_ms = $urandom();
            1:       run_ms = run_ms - $urandom_range(0, 20000);
            default: run_ms = run_ms + $urandom_range(0, span + span / 2 + 2000);
        endcase
        it.now_ms = run_ms;
        if (cur_wend != 0 && $urandom_range(0, 9) != 0) begin
            lo = cur_wstart * 1000;
            hi = cur_wend * 1000;
            it.play_ms = $urandom_range((lo > 1500) ? lo - 1500 : 0, hi + 1500);
        end else begin
            it.play_ms = $urandom();
        end
        it.reference_one = pick_reference();
        it.reference_two = pick_reference();
        it.average_one   = pick_average($signed(it.reference_one));
        it.average_two   = pick_average($signed(it.reference_two));
        return it;
    endfunction

    task automatic random_config();
        logic [LIMIT_W-1:0] lim;
        logic [PCT_W-1:0]   pct;
        logic [SEC_W-1:0]   cool;
        logic [SEC_W-1:0]   ws;
        logic [SEC_W-1:0]   we;
        logic [1:0]         sel;
        case ($urandom_range(0, 5))
            0:       lim = '1;
            1:       lim = '0;
            2:       lim = LIMIT_W'(255);
            3:       lim = LIMIT_W'($urandom_range(0, 511));
            default: lim = LIMIT_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 4))
            0:       pct = '0;
            1:       pct = '1;
            default: pct = PCT_W'($urandom_range(1, 60));
        endcase
        case ($urandom_range(0, 4))
            0:       cool = '0;
            1:       cool = '1;
            default: cool = SEC_W'($urandom_range(0, 8));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                ws = SEC_W'($urandom_range(0, 30));
                we = ws + SEC_W'($urandom_range(1, 40));
            end
            3: begin
                ws = SEC_W'($urandom_range(0, 65535));
                we = '1;
            end
            4: begin
                ws = SEC_W'($urandom_range(0, 65535));
                we = SEC_W'($urandom_range(1, 65535));
            end
            default: begin
                ws = SEC_W'($urandom_range(0, 65535));
                we = '0;
            end
        endcase
        sel = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                          : 2'($urandom_range(1, 2));
        set_config(sel, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   pct, cool, ws, we, lim);
    endtask

    task automatic test_reset_defaults();
        send_sample(sample(OP_EVAL, 32'd0, 32'd0, 11'sd1000, 10'd0, 11'sd1000, 10'd0));
        wait_idle();
    endtask

    task automatic test_cooldown_and_restart();
        set_config(SEL_ONE, 1'b0, 1'b1, 8'd10, 16'd5, 16'd0, 16'd0, 9'd2);
        send_sample(sample(OP_EVAL, 32'd100, 32'd7, 11'sd1000, 10'd900, 11'sd5, 10'd9));
        send_sample(sample(OP_EVAL, 32'd5100, 32'd7, 11'sd1000, 10'd900, 11'sd5, 10'd9));
        send_sample(sample(OP_EVAL, 32'd5101, 32'd7, 11'sd1000, 10'd900, 11'sd5, 10'd9));
        // clock rollback
        send_sample(sample(OP_EVAL, 32'd50, 32'd7, 11'sd1000, 10'd900, 11'sd5, 10'd9));
        send_sample(sample(OP_EVAL, 32'd5051, 32'd7, 11'sd1000, 10'd901, 11'sd5, 10'd9));
        send_sample(sample(OP_EVAL, 32'd5051, 32'd7, 11'sd1000, 10'd1023, 11'sd5, 10'd9));
        send_sample(sample(OP_EVAL, 32'd5051, 32'd7, -11'sd1, 10'd0, 11'sd5, 10'd9));
        send_sample(sample(OP_EVAL, 32'd5051, 32'd7, 11'sd0, 10'd0, 11'sd5, 10'd9));
        send_sample(sample(OP_EVAL, 32'd5051, 32'd7, 11'h400, 10'd0, 11'sd5, 10'd9));
        send_sample(sample(OP_EVAL, 32'd5051, 32'd7, 11'sd1000, 10'd900, 11'sd5, 10'd9));
        send_sample(sample(OP_RESTART, 32'd9999, 32'd7, 11'sd1000, 10'd900, 11'sd5, 10'd9));
        send_sample(sample(OP_EVAL, 32'd0, 32'd0, 11'sd1023, 10'd0, 11'sd5, 10'd9));
        wait_idle();
    endtask

    task automatic test_window_sensor_two();
        set_config(SEL_TWO, 1'b1, 1'b0, 8'd255, 16'd0, 16'd1, 16'd2, 9'h1FF);
        send_sample(sample(OP_EVAL, 32'd10, 32'd999, 11'sd1023, 10'd0, 11'sd1, 10'd1023));
        send_sample(sample(OP_EVAL, 32'd11, 32'd1000, 11'sd1023, 10'd0, 11'sd1, 10'd1023));
        send_sample(sample(OP_EVAL, 32'd11, 32'd1999, 11'sd1023, 10'd0, 11'sd1, 10'd1023));
        send_sample(sample(OP_EVAL, 32'd12, 32'd1999, 11'sd1023, 10'd0, 11'sd1, 10'd1023));
        send_sample(sample(OP_EVAL, 32'd13, 32'd2000, 11'sd1023, 10'd0, 11'sd1, 10'd1023));
        send_sample(sample(OP_EVAL, 32'd14, 32'd1500, 11'sd1023, 10'd0, 11'sd100, 10'd354));
        send_sample(sample(OP_EVAL, 32'd15, 32'd1500, 11'sd1023, 10'd0, 11'sd100, 10'd355));
        wait_idle();
    endtask

    task automatic test_extremes();
        // unused selector, negative repeat limit
        set_config(2'd3, 1'b0, 1'b1, 8'd0, 16'd0, 16'd0, 16'd0, 9'h100);
        send_sample(sample(OP_EVAL, 32'd500, 32'd0, 11'sd1000, 10'd0, 11'sd1000, 10'd0));
        wait_idle();
        set_config(SEL_ONE, 1'b1, 1'b0, 8'd0, 16'hFFFF, 16'd0, 16'hFFFF, 9'd0);
        send_sample(sample(OP_RESTART, 32'd0, 32'd0, 11'sd0, 10'd0, 11'sd0, 10'd0));
        send_sample(sample(OP_EVAL, 32'hFFFF_0000, 32'd65534999, 11'sd1022, 10'd1023,
                           11'sd0, 10'd0));
        send_sample(sample(OP_EVAL, 32'hFFFF_FFFF, 32'd65534999, 11'sd1022, 10'd1023,
                           11'sd0, 10'd0));
        send_sample(sample(OP_EVAL, 32'd0, 32'd0, 11'sd1022, 10'd1023, 11'sd0, 10'd0));
        send_sample(sample(OP_EVAL, 32'd65535001, 32'hFFFF_FFFF, 11'sd1022, 10'd1023,
                           11'sd0, 10'd0));
        send_sample(sample(OP_EVAL, 32'd65535001, 32'd65534999, 11'sd1022, 10'd1023,
                           11'sd0, 10'd0));
        wait_idle();
    endtask

    task automatic test_counter_saturation();
        stall_mode = 2;
        gap_max    = 3;
        set_config(SEL_ONE, 1'b1, 1'b1, 8'd0, 16'd0, 16'd0, 16'd0, 9'd255);
        send_sample(sample(OP_RESTART, 32'd0, 32'd0, 11'sd0, 10'd0, 11'sd0, 10'd0));
        for (int i = 0; i < 300; i++)
            send_sample(sample(OP_EVAL, TIME_W'(1000 + i), $urandom(), 11'sd1,
                               AVG_W'($urandom_range(2, 1023)), pick_reference(),
                               AVG_W'($urandom())));
        send_sample(sample(OP_RESTART, $urandom(), $urandom(), 11'sd1, 10'd2, 11'sd1, 10'd2));
        wait_idle();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 11; phase++) begin
            stall_mode = phase % 4;
            gap_max    = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
            random_config();
            repeat (114) send_sample(random_sample());
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.op            = OP_EVAL;
        in_ch.now_ms        = '0;
        in_ch.play_ms       = '0;
        in_ch.reference_one = '0;
        in_ch.reference_two = '0;
        in_ch.average_one   = '0;
        in_ch.average_two   = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_cooldown_and_restart();
        test_window_sensor_two();
        test_extremes();
        test_counter_saturation();
        test_random();
        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
